### hdl/ifp_pkg.sv
// Shared types, constants and helper functions of the sensor frame parser.
// Used by ifp_front, ifp_job_queue, ifp_back and the top level; no dependencies.
package ifp_pkg;

    localparam int NUM_WORDS   = 9;
    localparam int ANGLE_WORDS = 3;
    localparam int IMU6_WORDS  = 6;
    localparam int JOB_DEPTH   = 2;
    localparam int JOB_PTR_W   = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
    localparam int JOB_CNT_W   = $clog2(JOB_DEPTH + 1);

    localparam logic [7:0]  SYNC0_FIRST  = 8'h55;
    localparam logic [7:0]  SYNC0_SECOND = 8'h55;
    localparam logic [7:0]  SYNC1_FIRST  = 8'h5A;
    localparam logic [7:0]  SYNC1_SECOND = 8'hA5;
    localparam logic [7:0]  TYPE_ANGLE   = 8'h01;
    localparam logic [7:0]  TYPE_IMU6    = 8'h03;
    localparam logic [7:0]  TAG_FLOAT9   = 8'h91;
    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [3:0]  QTY_ANGLE_BASE = 4'd6;
    localparam logic [3:0]  SLOT_NONE    = 4'd15;

    typedef enum logic [2:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_HEADER,
        PH_PAYLOAD,
        PH_SUMBYTE
    } t_phase;

    typedef enum logic [1:0] {
        JOB_ERR,
        JOB_ANGLE,
        JOB_IMU6,
        JOB_FLOAT9
    } t_job_kind;

    typedef logic [NUM_WORDS-1:0][31:0] t_words;

    typedef struct packed {
        t_job_kind kind;
        t_words    words;
    } t_job;

    // One byte of CRC-16, polynomial 0x1021, MSB first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // Result slot of the float word at payload offset 12 + 4*g.
    function automatic logic [3:0] f32_slot(input logic [3:0] g);
        logic [3:0] s;
        case (g)
            4'd0:    s = 4'd0;
            4'd1:    s = 4'd1;
            4'd2:    s = 4'd2;
            4'd3:    s = 4'd4;
            4'd4:    s = 4'd3;
            4'd5:    s = 4'd5;
            4'd9:    s = 4'd7;
            4'd10:   s = 4'd6;
            4'd11:   s = 4'd8;
            default: s = SLOT_NONE;
        endcase
        return s;
    endfunction

endpackage

### hdl/ifp_front.sv
// Front end of the frame parser: byte-level framing, sum/CRC check, word capture.
// Emits one job per closed frame that yields results. Depends on ifp_pkg.
module ifp_front import ifp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_byte_valid,
    input  logic [7:0] i_rx_byte,
    input  logic       i_cfg_wr,
    input  logic       i_frame_mode,
    output logic       o_job_push,
    output t_job       o_job
);

    t_phase      r_phase, n_phase;
    logic        r_mode;
    logic [15:0] r_pos, n_pos;
    logic [15:0] r_len, n_len;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_sum, n_sum;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_exp, n_exp;
    t_words      r_words, n_words;

    logic [7:0]  w_first, w_second;
    logic [15:0] w_pos_inc;
    logic        w_pay_done;
    logic        w_cap_en;
    logic [3:0]  w_cap_idx;
    logic [1:0]  w_cap_lane;
    logic [5:0]  w_off;
    logic [3:0]  w_slot;

    assign w_first    = r_mode ? SYNC1_FIRST : SYNC0_FIRST;
    assign w_second   = r_mode ? SYNC1_SECOND : SYNC0_SECOND;
    assign w_pos_inc  = r_pos + 16'd1;
    assign w_pay_done = (w_pos_inc >= r_len);
    assign w_off      = 6'(r_pos - 16'd12);
    assign w_slot     = f32_slot(w_off[5:2]);

    // Capture target of the current payload byte
    always_comb begin
        w_cap_en   = 1'b0;
        w_cap_idx  = 4'd0;
        w_cap_lane = 2'd0;
        if (!r_mode) begin
            w_cap_en   = (r_pos < 16'd12);
            w_cap_idx  = {1'b0, r_pos[3:1]};
            w_cap_lane = {1'b0, r_pos[0]};
        end else begin
            w_cap_en   = (r_pos >= 16'd12) && (r_pos < 16'd60) && (w_slot != SLOT_NONE);
            w_cap_idx  = w_slot;
            w_cap_lane = r_pos[1:0];
        end
    end

    // Next state
    always_comb begin
        n_phase = r_phase;
        if (i_cfg_wr) begin
            n_phase = PH_HUNT1;
        end else if (i_byte_valid) begin
            unique case (r_phase)
                PH_HUNT1: begin
                    if (i_rx_byte == w_first) n_phase = PH_HUNT2;
                end
                PH_HUNT2: begin
                    if (i_rx_byte == w_second)     n_phase = PH_HEADER;
                    else if (i_rx_byte != w_first) n_phase = PH_HUNT1;
                end
                PH_HEADER: begin
                    if (!r_mode) begin
                        if (r_pos != 16'd0)
                            n_phase = (i_rx_byte == 8'd0) ? PH_SUMBYTE : PH_PAYLOAD;
                    end else if (r_pos[1:0] == 2'd3) begin
                        n_phase = (r_len == 16'd0) ? PH_HUNT1 : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if (w_pay_done) n_phase = r_mode ? PH_HUNT1 : PH_SUMBYTE;
                end
                PH_SUMBYTE: n_phase = PH_HUNT1;
                default:    n_phase = PH_HUNT1;
            endcase
        end
    end

    // Datapath and job output
    always_comb begin
        n_pos      = r_pos;
        n_len      = r_len;
        n_type     = r_type;
        n_sum      = r_sum;
        n_crc      = r_crc;
        n_exp      = r_exp;
        n_words    = r_words;
        o_job_push = 1'b0;
        o_job.kind = JOB_ERR;
        if (i_cfg_wr) begin
            n_pos = '0;
        end else if (i_byte_valid) begin
            unique case (r_phase)
                PH_HUNT2: begin
                    if (i_rx_byte == w_second) begin
                        n_pos   = '0;
                        n_len   = '0;
                        n_type  = '0;
                        n_crc   = '0;
                        n_exp   = '0;
                        n_words = '0;
                        n_sum   = 8'(w_first + w_second);
                    end
                end
                PH_HEADER: begin
                    if (!r_mode) begin
                        n_sum = r_sum + i_rx_byte;
                        if (r_pos == 16'd0) begin
                            n_type = i_rx_byte;
                            n_pos  = 16'd1;
                        end else begin
                            n_len = {8'd0, i_rx_byte};
                            n_pos = '0;
                        end
                    end else begin
                        case (r_pos[1:0])
                            2'd0:    n_len = {8'd0, i_rx_byte};
                            2'd1:    n_len = {i_rx_byte, r_len[7:0]};
                            2'd2:    n_exp = {8'd0, i_rx_byte};
                            default: n_exp = {i_rx_byte, r_exp[7:0]};
                        endcase
                        if (r_pos[1:0] == 2'd3) begin
                            n_pos = '0;
                            // empty frame: only the CRC check can produce a result
                            if (r_len == 16'd0 && r_crc != n_exp) o_job_push = 1'b1;
                        end else begin
                            n_pos = w_pos_inc;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    if (w_cap_en) begin
                        for (int i = 0; i < NUM_WORDS; i++) begin
                            if (w_cap_idx == 4'(i))
                                n_words[i][{w_cap_lane, 3'b000} +: 8] = i_rx_byte;
                        end
                    end
                    if (!r_mode) begin
                        n_sum = r_sum + i_rx_byte;
                    end else begin
                        n_crc = crc16_byte(r_crc, i_rx_byte);
                        if (r_pos == 16'd0) n_type = i_rx_byte;
                    end
                    n_pos = w_pay_done ? 16'd0 : w_pos_inc;
                    if (w_pay_done && r_mode) begin
                        if (n_crc != r_exp) begin
                            o_job_push = 1'b1;
                        end else if (n_type == TAG_FLOAT9) begin
                            o_job_push = 1'b1;
                            o_job.kind = JOB_FLOAT9;
                        end
                    end
                end
                PH_SUMBYTE: begin
                    if (r_type == TYPE_ANGLE || r_type == TYPE_IMU6) begin
                        o_job_push = 1'b1;
                        if (r_sum == i_rx_byte)
                            o_job.kind = (r_type == TYPE_ANGLE) ? JOB_ANGLE : JOB_IMU6;
                    end
                end
                default: ;
            endcase
        end
        o_job.words = n_words;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT1;
            r_mode  <= 1'b0;
            r_pos   <= '0;
            r_len   <= '0;
            r_type  <= '0;
            r_sum   <= '0;
            r_crc   <= '0;
            r_exp   <= '0;
        end else begin
            r_phase <= n_phase;
            if (i_cfg_wr) r_mode <= i_frame_mode;
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_type  <= n_type;
            r_sum   <= n_sum;
            r_crc   <= n_crc;
            r_exp   <= n_exp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_words <= n_words;
    end

endmodule

### hdl/ifp_job_queue.sv
// Short job queue between the parser front end and the result emitter.
// Depends on ifp_pkg (t_job, JOB_DEPTH).
module ifp_job_queue import ifp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_head
);

    t_job                 r_mem [JOB_DEPTH];
    logic [JOB_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [JOB_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [JOB_CNT_W-1:0] r_count, n_count;
    logic                 w_do_push, w_do_pop;

    assign o_full    = (r_count == JOB_CNT_W'(JOB_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_head    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push)
            n_wr_ptr = (r_wr_ptr == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        if (w_do_pop)
            n_rd_ptr = (r_rd_ptr == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        if (w_do_push && !w_do_pop)      n_count = r_count + 1'b1;
        else if (!w_do_push && w_do_pop) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) r_mem[r_wr_ptr] <= i_job;
    end

endmodule

### hdl/ifp_back.sv
// Result emitter: walks the head job one result beat per pop.
// Depends on ifp_pkg (t_job, kinds, word counts).
module ifp_back import ifp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_valid,
    input  t_job        i_job,
    input  logic        i_pop,
    output logic        o_job_done,
    output logic        o_empty,
    output logic        o_status,
    output logic [3:0]  o_quantity,
    output logic [31:0] o_raw_value,
    output logic        o_last_of_frame
);

    logic [3:0]  r_emit_idx, n_emit_idx;
    logic [31:0] w_word;

    // Select the word of the current beat
    always_comb begin
        w_word = '0;
        for (int i = 0; i < NUM_WORDS; i++) begin
            if (r_emit_idx == 4'(i)) w_word = i_job.words[i];
        end
    end

    always_comb begin
        o_status        = 1'b0;
        o_quantity      = r_emit_idx;
        o_raw_value     = w_word;
        o_last_of_frame = 1'b0;
        unique case (i_job.kind)
            JOB_ERR: begin
                o_status        = 1'b1;
                o_quantity      = 4'd0;
                o_raw_value     = '0;
                o_last_of_frame = 1'b1;
            end
            JOB_ANGLE: begin
                o_quantity      = QTY_ANGLE_BASE + r_emit_idx;
                o_raw_value     = {{16{w_word[15]}}, w_word[15:0]};
                o_last_of_frame = (r_emit_idx == 4'(ANGLE_WORDS - 1));
            end
            JOB_IMU6: begin
                o_raw_value     = {{16{w_word[15]}}, w_word[15:0]};
                o_last_of_frame = (r_emit_idx == 4'(IMU6_WORDS - 1));
            end
            default: begin
                o_last_of_frame = (r_emit_idx == 4'(NUM_WORDS - 1));
            end
        endcase
    end

    assign o_empty    = !i_job_valid;
    assign o_job_done = i_pop && i_job_valid && o_last_of_frame;

    always_comb begin
        n_emit_idx = r_emit_idx;
        if (i_pop && i_job_valid)
            n_emit_idx = o_last_of_frame ? 4'd0 : r_emit_idx + 4'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit_idx <= '0;
        end else begin
            r_emit_idx <= n_emit_idx;
        end
    end

endmodule

### hdl/imu_frame_parser_checked_core.sv
// Sensor frame parser top level: one byte accepted per cycle unless full, results popped one per cycle.
// Latency: results of a frame are on the ports the cycle after its closing byte is pushed,
// provided no earlier frame's results still wait; otherwise they follow those.
// Throughput: push is taken every cycle while full is low; full rises only while two frames' results wait.
// A frame yields at most nine result beats, emitted one per pop from the job queue.
// Reset (synchronous, active low): hunt for a header, mode 0, queue empty.
// Depends on ifp_pkg, ifp_front, ifp_job_queue and ifp_back.
module imu_frame_parser_checked_core import ifp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input, queue style
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_frame_mode,
    // result output, queue style
    output logic        empty,
    input  logic        pop,
    output logic        o_status,
    output logic [3:0]  o_quantity,
    output logic [31:0] o_raw_value,
    output logic        o_last_of_frame
);

    logic w_byte_acc;
    logic w_cfg_wr;
    logic w_job_push;
    t_job w_job;
    logic w_q_full;
    logic w_q_valid;
    t_job w_q_head;
    logic w_job_done;

    // Always ready; write the mode register only while the block is idle; the block does not check it.
    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid;

    // Hold off bytes while the job queue has no room: any byte may close a frame.
    assign full       = w_q_full;
    assign w_byte_acc = push && !w_q_full;

    ifp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (w_byte_acc),
        .i_rx_byte    (i_rx_byte),
        .i_cfg_wr     (w_cfg_wr),
        .i_frame_mode (i_frame_mode),
        .o_job_push   (w_job_push),
        .o_job        (w_job)
    );

    // Decouple the parser from result backpressure
    ifp_job_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_job   (w_job),
        .i_pop   (w_job_done),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_head  (w_q_head)
    );

    // Advance through the head job one beat per pop, drop it after its last beat
    ifp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (w_q_valid),
        .i_job           (w_q_head),
        .i_pop           (pop),
        .o_job_done      (w_job_done),
        .o_empty         (empty),
        .o_status        (o_status),
        .o_quantity      (o_quantity),
        .o_raw_value     (o_raw_value),
        .o_last_of_frame (o_last_of_frame)
    );

`ifndef NO_ASSERTIONS
    a_no_job_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_job_push |-> !w_q_full)
        else $error("job pushed into a full queue");

    a_error_beat_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status) |-> (o_last_of_frame && o_quantity == 4'd0 && o_raw_value == '0))
        else $error("error result malformed");

    a_frame_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_last_of_frame) |=> !empty)
        else $error("frame results cut short");

    a_quantity_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_last_of_frame) |=> (o_quantity == 4'($past(o_quantity) + 4'd1)))
        else $error("quantity did not advance by one within a frame");
`endif

endmodule
